[design/lgg_pkg.sv]
// ----------------------------------------------------------------------------
// lgg_pkg
// Shared types and codes for the life grid generation block.
// ----------------------------------------------------------------------------
package lgg_pkg;

    localparam logic [1:0] CMD_SET  = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SET,
        ST_READ,
        ST_STEP
    } t_state;

    typedef enum logic [1:0] {
        SRC_SET,
        SRC_READ,
        SRC_STEP
    } t_src;

    typedef struct packed {
        logic capture;
        logic rd_next;
        logic shift;
        logic next_zero;
        logic out_load;
        logic wr_en;
        logic last;
        t_src src;
    } t_dp_ctrl;

endpackage

[design/life_grid_generation.sv]
// ----------------------------------------------------------------------------
// life_grid_generation
// Bounded Conway Life grid with set, step and read commands.
//
// Channel  Dir  Words per command          Contents
// s_axis   in   one                        tuser command, tdata row and col
// m_axis   out  set: 1, step/read: N rows  tdata row index and row cells
//
// Each command reads rows through the single read port of the grid memory,
// one row per cycle while m_axis back-pressure does not hold the sweep.
// Reset clears every row to dead at once through per-row valid bits.
// Back-pressure on m_axis holds the whole row sweep in place.
// A new command is taken only once the previous one has issued all its words.
// ----------------------------------------------------------------------------
module life_grid_generation #(
    parameter int GRID_SIZE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // row[3:0], col[7:4]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // row_index[3:0], row_bits[19:4], zero[23:20]
    output logic        m_axis_tlast
);
    import lgg_pkg::*;

    t_dp_ctrl    dp_ctrl;
    logic        adv;
    logic [3:0]  row_index;
    logic [15:0] row_bits;

    lgg_ctrl #(
        .GRID_SIZE (GRID_SIZE)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_command (s_axis_tuser),
        .i_adv     (adv),
        .o_ready   (s_axis_tready),
        .o_ctrl    (dp_ctrl)
    );

    lgg_dpath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (dp_ctrl),
        .i_command   (s_axis_tuser),
        .i_row       (s_axis_tdata[3:0]),
        .i_col       (s_axis_tdata[7:4]),
        .i_out_ready (m_axis_tready),
        .o_adv       (adv),
        .o_out_valid (m_axis_tvalid),
        .o_row_index (row_index),
        .o_row_bits  (row_bits),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, row_bits, row_index};

endmodule

[design/lgg_ctrl.sv]
// ----------------------------------------------------------------------------
// lgg_ctrl
// Command sequencer: walks the row sweep for set, read and step commands.
// ----------------------------------------------------------------------------
module lgg_ctrl #(
    parameter int GRID_SIZE = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_command,
    input  logic              i_adv,
    output logic              o_ready,
    output lgg_pkg::t_dp_ctrl o_ctrl
);
    import lgg_pkg::*;

    localparam int KW = $clog2(GRID_SIZE + 2);
    localparam logic [KW-1:0] K_LAST_ROW = KW'(GRID_SIZE);
    localparam logic [KW-1:0] K_FLUSH    = KW'(GRID_SIZE + 1);
    localparam logic [KW-1:0] K_FIRST_WR = KW'(2);
    localparam logic [KW-1:0] K_ONE      = KW'(1);

    t_state        r_state, n_state;
    logic [KW-1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        o_ready = 1'b0;
        o_ctrl  = '0;
        o_ctrl.src = SRC_SET;
        case (r_state)
            ST_IDLE: begin
                o_ready = i_adv;
                if (i_valid && i_adv) begin
                    n_k = K_ONE;
                    case (i_command)
                        CMD_SET: begin
                            o_ctrl.capture = 1'b1;
                            n_state = ST_SET;
                        end
                        CMD_STEP: begin
                            o_ctrl.capture = 1'b1;
                            n_state = ST_STEP;
                        end
                        CMD_READ: begin
                            o_ctrl.capture = 1'b1;
                            n_state = ST_READ;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SET: begin
                o_ctrl.src = SRC_SET;
                if (i_adv) begin
                    o_ctrl.out_load = 1'b1;
                    o_ctrl.wr_en    = 1'b1;
                    o_ctrl.last     = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                o_ctrl.src = SRC_READ;
                if (i_adv) begin
                    o_ctrl.out_load = 1'b1;
                    o_ctrl.rd_next  = (r_k < K_LAST_ROW);
                    o_ctrl.last     = (r_k == K_LAST_ROW);
                    n_k = r_k + K_ONE;
                    if (r_k == K_LAST_ROW) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_STEP: begin
                o_ctrl.src = SRC_STEP;
                if (i_adv) begin
                    o_ctrl.shift     = 1'b1;
                    o_ctrl.rd_next   = (r_k < K_LAST_ROW);
                    o_ctrl.next_zero = (r_k == K_FLUSH);
                    o_ctrl.out_load  = (r_k >= K_FIRST_WR);
                    o_ctrl.wr_en     = (r_k >= K_FIRST_WR);
                    o_ctrl.last      = (r_k == K_FLUSH);
                    n_k = r_k + K_ONE;
                    if (r_k == K_FLUSH) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[design/lgg_dpath.sv]
// ----------------------------------------------------------------------------
// lgg_dpath
// Grid memory, three-row window, next-generation logic and output register.
// ----------------------------------------------------------------------------
module lgg_dpath #(
    parameter int GRID_SIZE = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lgg_pkg::t_dp_ctrl i_ctrl,
    input  logic [1:0]        i_command,
    input  logic [3:0]        i_row,
    input  logic [3:0]        i_col,
    input  logic              i_out_ready,
    output logic              o_adv,
    output logic              o_out_valid,
    output logic [3:0]        o_row_index,
    output logic [15:0]       o_row_bits,
    output logic              o_last
);
    import lgg_pkg::*;

    localparam int N  = GRID_SIZE;
    localparam int AW = $clog2(GRID_SIZE);

    logic [N-1:0]  mem [N];
    logic [N-1:0]  r_row_vld;
    logic [N-1:0]  r_rd_data;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] r_out_ptr;
    logic [AW-1:0] r_set_addr;
    logic [3:0]    r_set_row;
    logic [3:0]    r_set_col;
    logic          r_set_ok;
    logic [N-1:0]  r_prev;
    logic [N-1:0]  r_cur;
    logic          r_out_vld;
    logic [3:0]    r_out_idx;
    logic [15:0]   r_out_bits;
    logic          r_out_last;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [N-1:0]  rd_row;
    logic [N-1:0]  nxt_row;
    logic [N-1:0]  life_row;
    logic [N-1:0]  set_row;
    logic [N+1:0]  pad_p, pad_c, pad_n;
    logic [3:0]    nbr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [N-1:0]  wr_data;
    logic          set_ok;

    assign o_adv = !r_out_vld || i_out_ready;

    assign set_ok  = (int'(i_row) < N) && (int'(i_col) < N);
    assign rd_en   = i_ctrl.capture || i_ctrl.rd_next;
    assign rd_addr = (i_ctrl.capture && (i_command == CMD_SET)) ? AW'(i_row) :
                     (i_ctrl.capture ? '0 : r_rd_ptr);

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vld  <= r_row_vld[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[wr_addr] <= 1'b1;
        end
    end

    assign rd_row  = r_rd_vld ? r_rd_data : '0;
    assign nxt_row = i_ctrl.next_zero ? '0 : rd_row;
    assign set_row = rd_row | (N'(1) << r_set_col);

    assign pad_p = {1'b0, r_prev, 1'b0};
    assign pad_c = {1'b0, r_cur, 1'b0};
    assign pad_n = {1'b0, nxt_row, 1'b0};

    always_comb begin
        life_row = '0;
        nbr      = '0;
        for (int c = 0; c < N; c++) begin
            nbr = 4'(pad_p[c]) + 4'(pad_p[c+1]) + 4'(pad_p[c+2])
                + 4'(pad_c[c]) + 4'(pad_c[c+2])
                + 4'(pad_n[c]) + 4'(pad_n[c+1]) + 4'(pad_n[c+2]);
            life_row[c] = (nbr == 4'd3) || (pad_c[c+1] && (nbr == 4'd2));
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_out_ptr;
        wr_data = life_row;
        if (i_ctrl.wr_en) begin
            if (i_ctrl.src == SRC_SET) begin
                wr_en   = r_set_ok;
                wr_addr = r_set_addr;
                wr_data = set_row;
            end else begin
                wr_en = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_set_addr <= AW'(i_row);
            r_set_row  <= i_row;
            r_set_col  <= i_col;
            r_set_ok   <= set_ok;
            r_rd_ptr   <= AW'(1);
            r_out_ptr  <= '0;
            r_prev     <= '0;
            r_cur      <= '0;
        end else begin
            if (i_ctrl.rd_next) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_ctrl.shift) begin
                r_prev <= r_cur;
                r_cur  <= nxt_row;
            end
            if (i_ctrl.out_load && (i_ctrl.src != SRC_SET)) begin
                r_out_ptr <= r_out_ptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_out_last <= i_ctrl.last;
            case (i_ctrl.src)
                SRC_SET: begin
                    r_out_idx  <= r_set_row;
                    r_out_bits <= r_set_ok ? 16'(set_row) : 16'd0;
                end
                SRC_READ: begin
                    r_out_idx  <= 4'(r_out_ptr);
                    r_out_bits <= 16'(rd_row);
                end
                SRC_STEP: begin
                    r_out_idx  <= 4'(r_out_ptr);
                    r_out_bits <= 16'(life_row);
                end
                default: begin
                    r_out_idx  <= 4'(r_out_ptr);
                    r_out_bits <= 16'd0;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_row_index = r_out_idx;
    assign o_row_bits  = r_out_bits;
    assign o_last      = r_out_last;

endmodule

[verif/life_grid_generation_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_generation_tb
// Drives set, step, read and unused commands into the life grid block and
// checks every returned row word against a cycle-free model of the grid or
// against typed expected rows, first from a short directed table and then from
// clustered random commands, with the sender and receiver idling in several phases.
// ----------------------------------------------------------------------------
module life_grid_generation_tb;

    import lgg_pkg::*;

    localparam int N          = 16;
    localparam int CLK_HALF   = 2;
    localparam int RANDOM_CMD = 386;
    localparam int STALL_MAX  = 3000;
    localparam int DRAIN_WAIT = 2 * N + 8;
    localparam int DIR_LEN    = 24;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum int {
        PH_NONE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } t_idle_phase;

    typedef struct packed {
        logic [3:0]  idx;
        logic [15:0] bits;
        logic        last;
    } t_row_word;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  row;
        logic [3:0]  col;
        logic        typed;
        logic [15:0] typed_bits;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // row[3:0], col[7:4]
    logic [1:0]  s_axis_tuser;   // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // row_index[3:0], row_bits[19:4], zero[23:20]
    logic        m_axis_tlast;

    logic [N-1:0] life_grid [N];
    t_row_word    pending_rows [$];
    t_idle_phase  idle_phase;
    int           error_count;
    int           quiet_cycles;

    t_stim_row directed_table [DIR_LEN] = '{
        '{CMD_READ,   4'd0,  4'd0,  1'b1, 16'h0000},
        '{CMD_STEP,   4'd0,  4'd0,  1'b1, 16'h0000},
        '{CMD_UNUSED, 4'd15, 4'd15, 1'b0, 16'h0000},
        '{CMD_SET,    4'd0,  4'd0,  1'b1, 16'h0001},
        '{CMD_SET,    4'd15, 4'd15, 1'b1, 16'h8000},
        '{CMD_SET,    4'd0,  4'd15, 1'b1, 16'h8001},
        '{CMD_SET,    4'd15, 4'd0,  1'b1, 16'h8001},
        '{CMD_SET,    4'd0,  4'd0,  1'b1, 16'h8001},
        '{CMD_STEP,   4'd0,  4'd0,  1'b1, 16'h0000},
        '{CMD_READ,   4'd0,  4'd0,  1'b1, 16'h0000},
        '{CMD_SET,    4'd7,  4'd6,  1'b0, 16'h0000},
        '{CMD_SET,    4'd7,  4'd7,  1'b0, 16'h0000},
        '{CMD_SET,    4'd7,  4'd8,  1'b0, 16'h0000},
        '{CMD_STEP,   4'd0,  4'd0,  1'b0, 16'h0000},
        '{CMD_STEP,   4'd0,  4'd0,  1'b0, 16'h0000},
        '{CMD_SET,    4'd0,  4'd14, 1'b0, 16'h0000},
        '{CMD_SET,    4'd0,  4'd15, 1'b0, 16'h0000},
        '{CMD_SET,    4'd1,  4'd14, 1'b0, 16'h0000},
        '{CMD_SET,    4'd1,  4'd15, 1'b0, 16'h0000},
        '{CMD_SET,    4'd10, 4'd0,  1'b0, 16'h0000},
        '{CMD_SET,    4'd11, 4'd0,  1'b0, 16'h0000},
        '{CMD_STEP,   4'd0,  4'd0,  1'b0, 16'h0000},
        '{CMD_UNUSED, 4'd0,  4'd0,  1'b0, 16'h0000},
        '{CMD_READ,   4'd0,  4'd0,  1'b0, 16'h0000}
    };

    life_grid_generation #(
        .GRID_SIZE(N)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic int send_idle_pct(t_idle_phase ph);
        if (ph == PH_SEND_IDLE) begin
            return 83;
        end else if (ph == PH_BOTH) begin
            return 6;
        end
        return 0;
    endfunction

    function automatic int recv_stall_pct(t_idle_phase ph);
        if (ph == PH_RECV_STALL) begin
            return 83;
        end else if (ph == PH_BOTH) begin
            return 6;
        end
        return 0;
    endfunction

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic queue_all_rows();
        for (int r = 0; r < N; r++) begin
            pending_rows.push_back('{idx: r[3:0], bits: life_grid[r], last: (r == N - 1)});
        end
    endtask

    // Updates the grid for one accepted command and, when asked, queues the rows it returns.
    task automatic evolve_grid(logic [1:0] cmd, logic [3:0] row, logic [3:0] col, bit queue_rows);
        logic [N-1:0] snap [N];
        int           nb;
        int           rr;
        int           cc;
        if (cmd == CMD_SET) begin
            life_grid[row][col] = 1'b1;
            if (queue_rows) begin
                pending_rows.push_back('{idx: row, bits: life_grid[row], last: 1'b1});
            end
        end else if (cmd == CMD_STEP || cmd == CMD_READ) begin
            if (cmd == CMD_STEP) begin
                snap = life_grid;
                for (int r = 0; r < N; r++) begin
                    for (int c = 0; c < N; c++) begin
                        nb = 0;
                        for (int dr = -1; dr <= 1; dr++) begin
                            for (int dc = -1; dc <= 1; dc++) begin
                                rr = r + dr;
                                cc = c + dc;
                                if ((dr != 0 || dc != 0) && rr >= 0 && rr < N && cc >= 0
                                        && cc < N) begin
                                    nb += snap[rr][cc];
                                end
                            end
                        end
                        life_grid[r][c] = (nb == 3) || (snap[r][c] && nb == 2);
                    end
                end
            end
            if (queue_rows) begin
                queue_all_rows();
            end
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_command(t_stim_row s);
        while ($urandom_range(0, 99) < send_idle_pct(idle_phase)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s.col, s.row};
        s_axis_tuser  <= s.cmd;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        if (s.typed) begin
            if (s.cmd == CMD_SET) begin
                pending_rows.push_back('{idx: s.row, bits: s.typed_bits, last: 1'b1});
            end else begin
                for (int r = 0; r < N; r++) begin
                    pending_rows.push_back('{idx: r[3:0], bits: s.typed_bits,
                                             last: (r == N - 1)});
                end
            end
            evolve_grid(s.cmd, s.row, s.col, 1'b0);
        end else begin
            evolve_grid(s.cmd, s.row, s.col, 1'b1);
        end
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct(idle_phase));
    end

    always @(posedge i_clk) begin
        t_row_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_rows.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata, 24'h0);
            end else begin
                want = pending_rows.pop_front();
                if (m_axis_tdata[3:0] !== want.idx) begin
                    report_mismatch("row_index", 24'(m_axis_tdata[3:0]), 24'(want.idx));
                end
                if (m_axis_tdata[19:4] !== want.bits) begin
                    report_mismatch("row_bits", 24'(m_axis_tdata[19:4]), 24'(want.bits));
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch("last", 24'(m_axis_tlast), 24'(want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_stim_row s;
        int        sent;
        logic [3:0] centre_row;
        logic [3:0] centre_col;
        int        pick;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        idle_phase    = PH_NONE;
        error_count   = 0;
        quiet_cycles  = 0;
        for (int r = 0; r < N; r++) begin
            life_grid[r] = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_LEN; i++) begin
            send_command(directed_table[i]);
        end

        // Sets gather around a wandering centre so that patterns form and evolve.
        sent       = 0;
        centre_row = 4'($urandom_range(0, N - 1));
        centre_col = 4'($urandom_range(0, N - 1));
        while (sent < RANDOM_CMD) begin
            idle_phase = t_idle_phase'((sent / 50) % 4);
            s.typed      = 1'b0;
            s.typed_bits = '0;
            s.row        = 4'($urandom_range(0, N - 1));
            s.col        = 4'($urandom_range(0, N - 1));
            pick         = $urandom_range(0, 99);
            if (pick < 45) begin
                s.cmd = CMD_SET;
                s.row = centre_row + 4'($urandom_range(0, 4)) - 4'd2;
                s.col = centre_col + 4'($urandom_range(0, 4)) - 4'd2;
            end else if (pick < 57) begin
                s.cmd = CMD_SET;
            end else if (pick < 80) begin
                s.cmd = CMD_STEP;
            end else if (pick < 93) begin
                s.cmd = CMD_READ;
            end else begin
                s.cmd = CMD_UNUSED;
            end
            if ($urandom_range(0, 99) < 8) begin
                centre_row = 4'($urandom_range(0, N - 1));
                centre_col = 4'($urandom_range(0, N - 1));
            end
            send_command(s);
            sent++;
        end
        s_axis_tvalid <= 1'b0;
        idle_phase = PH_NONE;

        while (pending_rows.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
design/lgg_pkg.sv
design/lgg_ctrl.sv
design/lgg_dpath.sv
design/life_grid_generation.sv
verif/life_grid_generation_tb.sv
